// ----- rtl/tpgmc_pkg.sv -----
package tpgmc_pkg;

    localparam int MAX_COLS  = 16;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int WIDTH_W   = 5;
    localparam int CELL_W    = 8;
    localparam int SCORE_W   = 17;
    localparam int GAIN_W    = CELL_W + 1;
    localparam int ROW_BITS  = MAX_COLS * SCORE_W;
    localparam int RAM_DEPTH = 2 * MAX_COLS;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_BEST_INIT,
        ST_BEST_RD,
        ST_BEST_ACC,
        ST_BEST_SCAN,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic             accept;
        logic             first_wr;
        logic             nxt_clear;
        logic             rd_en;
        logic             rd_ok;
        logic             cap_en;
        logic             cap_direct;
        logic             acc_clr;
        logic             row_wr;
        logic             bank_flip;
        logic             best_clr;
        logic             scan_en;
        logic             out_load;
        logic [COL_W-1:0] rd_row;
        logic [COL_W-1:0] row_idx;
    } ctl_cmd_t;

    typedef struct packed {
        logic             in_end;
        logic             complete;
        logic             first_pending;
        logic             end_q;
        logic             out_free;
        logic [COL_W-1:0] w_last;
    } ctl_sts_t;

endpackage

// ----- rtl/tpgmc_ram.sv -----
module tpgmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- rtl/tpgmc_ctrl.sv -----
module tpgmc_ctrl import tpgmc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    ctl_state_t       state_reg, state_next;
    logic [COL_W-1:0] r_reg, r_next;
    logic [1:0]       k_reg, k_next;
    logic             fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign fire     = in_valid && in_ready;

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                r_next = '0;
                k_next = '0;
                if (fire)
                begin
                    if (sts.complete)
                        state_next = sts.first_pending ? ST_FIRST : ST_UPD_RD;
                    else if (sts.in_end)
                        state_next = ST_BEST_INIT;
                end
            end
            ST_FIRST:
                state_next = sts.end_q ? ST_BEST_INIT : ST_IDLE;
            ST_UPD_RD:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                    state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                k_next = '0;
                if (r_reg == sts.w_last)
                begin
                    r_next     = '0;
                    state_next = sts.end_q ? ST_BEST_INIT : ST_IDLE;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_UPD_RD;
                end
            end
            ST_BEST_INIT:
            begin
                r_next     = '0;
                state_next = sts.first_pending ? ST_EMIT : ST_BEST_RD;
            end
            ST_BEST_RD:
                state_next = ST_BEST_ACC;
            ST_BEST_ACC:
            begin
                if (r_reg == sts.w_last)
                begin
                    r_next     = '0;
                    state_next = ST_BEST_SCAN;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_BEST_RD;
                end
            end
            ST_BEST_SCAN:
            begin
                r_next = r_reg + 1'b1;
                if (r_reg == COL_W'(MAX_COLS - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
                if (sts.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.accept  = fire;
        cmd.row_idx = r_reg;
        cmd.rd_row  = r_reg + COL_W'(k_reg) - 1'b1;
        case (state_reg)
            ST_FIRST:
                cmd.first_wr = 1'b1;
            ST_UPD_RD:
            begin
                cmd.nxt_clear = (r_reg == '0) && (k_reg == 2'd0);
                cmd.acc_clr   = (k_reg == 2'd0);
                cmd.rd_en     = (k_reg != 2'd3);
                cmd.rd_ok     = !((k_reg == 2'd0) && (r_reg == '0)) &&
                                !((k_reg == 2'd2) && (r_reg == sts.w_last));
                cmd.cap_en    = (k_reg != 2'd0);
            end
            ST_UPD_WR:
            begin
                cmd.row_wr    = 1'b1;
                cmd.bank_flip = (r_reg == sts.w_last);
            end
            ST_BEST_INIT:
            begin
                cmd.best_clr = 1'b1;
                cmd.acc_clr  = 1'b1;
            end
            ST_BEST_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_ok  = 1'b1;
                cmd.rd_row = r_reg;
            end
            ST_BEST_ACC:
            begin
                cmd.cap_en     = 1'b1;
                cmd.cap_direct = 1'b1;
            end
            ST_BEST_SCAN:
                cmd.scan_en = 1'b1;
            ST_EMIT:
                cmd.out_load = sts.out_free;
            default:
                cmd.accept = fire;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ----- rtl/tpgmc_dpath.sv -----
module tpgmc_dpath import tpgmc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CELL_W-1:0]  cell_value,
    input  logic               grid_end,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] grid_width,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SCORE_W-1:0] best_total,
    output logic               short_row,
    input  ctl_cmd_t           cmd,
    output ctl_sts_t           sts
);

    logic [WIDTH_W-1:0]  grid_width_reg;
    logic [COL_W-1:0]    w_last;
    logic [MAX_COLS-1:0] colmask;
    logic [COL_W-1:0]    count_reg;
    logic                first_pending_reg;
    logic                end_reg;
    logic                short_reg;
    logic                bank_reg;
    logic                rd_ok_reg;
    logic [CELL_W-1:0]   row_buf_reg [MAX_COLS];
    logic [MAX_COLS-1:0] reach_reg [2][MAX_COLS];
    logic [MAX_COLS-1:0] rd_reach_reg;
    logic [SCORE_W-1:0]  acc_reg [MAX_COLS];
    logic [MAX_COLS-1:0] acc_valid_reg;
    logic [SCORE_W-1:0]  best_reg;
    logic                out_valid_reg;
    logic [SCORE_W-1:0]  best_total_reg;
    logic                short_row_reg;

    logic                               ram_we;
    logic [$clog2(RAM_DEPTH)-1:0]       ram_waddr;
    logic [$clog2(RAM_DEPTH)-1:0]       ram_raddr;
    logic [MAX_COLS-1:0][SCORE_W-1:0]   ram_wdata;
    logic [MAX_COLS-1:0][SCORE_W-1:0]   ram_rdata;
    logic [SCORE_W-1:0]                 start_score;
    logic [MAX_COLS-1:0][SCORE_W-1:0]   new_row;
    logic [MAX_COLS-1:0]                new_reach;
    logic [SCORE_W-1:0]                 cap_max [MAX_COLS];
    logic [MAX_COLS-1:0]                cap_any;
    logic                               complete;

    assign cfg_ready = 1'b1;

    // effective width, saturated to 1..MAX_COLS, kept as last column index
    always_comb
    begin
        if (grid_width_reg == '0)
            w_last = '0;
        else if (grid_width_reg > WIDTH_W'(MAX_COLS))
            w_last = COL_W'(MAX_COLS - 1);
        else
            w_last = COL_W'(grid_width_reg - 1'b1);
    end

    always_comb
    begin
        for (int i = 0; i < MAX_COLS; i++)
            colmask[i] = (COL_W'(i) <= w_last);
    end

    assign complete = (count_reg >= w_last);

    assign sts.in_end        = grid_end;
    assign sts.complete      = complete;
    assign sts.first_pending = first_pending_reg;
    assign sts.end_q         = end_reg;
    assign sts.out_free      = !out_valid_reg || out_ready;
    assign sts.w_last        = w_last;

    // first row: walkers at column 0 and the last column
    assign start_score = SCORE_W'({1'b0, row_buf_reg[0]}) +
                         ((w_last != '0) ? SCORE_W'(row_buf_reg[w_last]) : '0);

    always_comb
    begin
        logic [GAIN_W-1:0]  gain;
        logic [SCORE_W:0]   sum;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            gain = GAIN_W'(row_buf_reg[cmd.row_idx]) +
                   ((cmd.row_idx != COL_W'(i)) ? GAIN_W'(row_buf_reg[i]) : '0);
            sum  = {1'b0, acc_reg[i]} + (SCORE_W + 1)'(gain);
            new_row[i]   = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
            new_reach[i] = acc_valid_reg[i] && colmask[i];
        end
    end

    // best over the three source columns of each lane (one in direct mode)
    always_comb
    begin
        int c;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            cap_max[i] = '0;
            cap_any[i] = 1'b0;
            for (int d = 0; d < 3; d++)
            begin
                c = i - 1 + d;
                if ((!cmd.cap_direct || d == 1) && c >= 0 && c < MAX_COLS)
                begin
                    if (rd_reach_reg[COL_W'(c)] &&
                        (!cap_any[i] || ram_rdata[COL_W'(c)] > cap_max[i]))
                    begin
                        cap_max[i] = ram_rdata[COL_W'(c)];
                        cap_any[i] = 1'b1;
                    end
                end
            end
        end
    end

    assign ram_we    = cmd.first_wr || cmd.row_wr;
    assign ram_waddr = cmd.first_wr ? {bank_reg, COL_W'(0)} : {!bank_reg, cmd.row_idx};
    assign ram_raddr = {bank_reg, cmd.rd_row};

    always_comb
    begin
        for (int i = 0; i < MAX_COLS; i++)
            ram_wdata[i] = cmd.first_wr ? start_score : new_row[i];
    end

    tpgmc_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_score_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg    <= WIDTH_W'(MAX_COLS);
            count_reg         <= '0;
            first_pending_reg <= 1'b1;
            end_reg           <= 1'b0;
            short_reg         <= 1'b0;
            bank_reg          <= 1'b0;
            rd_ok_reg         <= 1'b0;
            rd_reach_reg      <= '0;
            acc_valid_reg     <= '0;
            out_valid_reg     <= 1'b0;
            for (int b = 0; b < 2; b++)
                for (int r = 0; r < MAX_COLS; r++)
                    reach_reg[b][r] <= '0;
        end
        else
        begin
            if (cfg_valid)
                grid_width_reg <= grid_width;

            if (cmd.accept)
            begin
                count_reg <= complete ? '0 : count_reg + 1'b1;
                end_reg   <= grid_end;
                short_reg <= !complete;
            end

            if (cmd.rd_en)
            begin
                rd_ok_reg    <= cmd.rd_ok;
                rd_reach_reg <= cmd.rd_ok ? (reach_reg[bank_reg][cmd.rd_row] & colmask) : '0;
            end

            if (cmd.acc_clr)
                acc_valid_reg <= '0;
            else if (cmd.cap_en)
            begin
                for (int i = 0; i < MAX_COLS; i++)
                    if (rd_ok_reg && cap_any[i])
                        acc_valid_reg[i] <= 1'b1;
            end

            if (cmd.first_wr)
            begin
                first_pending_reg <= 1'b0;
                for (int b = 0; b < 2; b++)
                    for (int r = 0; r < MAX_COLS; r++)
                        reach_reg[b][r] <= ((b == int'(bank_reg)) && (r == 0)) ?
                                           (MAX_COLS'(1) << w_last) : '0;
            end
            if (cmd.nxt_clear)
                for (int r = 0; r < MAX_COLS; r++)
                    reach_reg[!bank_reg][r] <= '0;
            if (cmd.row_wr)
                reach_reg[!bank_reg][cmd.row_idx] <= new_reach;
            if (cmd.bank_flip)
                bank_reg <= !bank_reg;

            // result leaves, table goes back to its empty state
            if (cmd.out_load)
            begin
                out_valid_reg     <= 1'b1;
                first_pending_reg <= 1'b1;
                count_reg         <= '0;
                for (int b = 0; b < 2; b++)
                    for (int r = 0; r < MAX_COLS; r++)
                        reach_reg[b][r] <= '0;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            row_buf_reg[count_reg] <= cell_value;

        if (cmd.cap_en)
            for (int i = 0; i < MAX_COLS; i++)
                if (rd_ok_reg && cap_any[i] && (!acc_valid_reg[i] || cap_max[i] > acc_reg[i]))
                    acc_reg[i] <= cap_max[i];

        if (cmd.best_clr)
            best_reg <= '0;
        else if (cmd.scan_en && acc_valid_reg[cmd.row_idx] && acc_reg[cmd.row_idx] > best_reg)
            best_reg <= acc_reg[cmd.row_idx];

        if (cmd.out_load)
        begin
            best_total_reg <= best_reg;
            short_row_reg  <= short_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_total = best_total_reg;
    assign short_row  = short_row_reg;

endmodule

// ----- rtl/two_path_grid_max_collect.sv -----
// a cell that does not close a row is only buffered; a cell closing the first row of a grid writes the start score
// a cell closing a later row runs the row update: three row reads and a write per column
// a grid end adds the final max search over the lane accumulators
// a new item is taken only in the idle state, once the work for the previous item is done
// reset: asynchronous active low; table empty, width 16, result register empty
module two_path_grid_max_collect import tpgmc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // input items, one grid cell each, row-major
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CELL_W-1:0]  cell_value,
    input  logic               grid_end,
    // width register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] grid_width,
    // result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SCORE_W-1:0] best_total,
    output logic               short_row
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequencer: row buffering, pair table update per row, final search
    tpgmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // row buffer, ping-pong score ram with reach bits, lane accumulators, result register
    tpgmc_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_value (cell_value),
        .grid_end   (grid_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .grid_width (grid_width),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .best_total (best_total),
        .short_row  (short_row),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
